@@ hdl/alt_pkg.sv @@
// Shared types, constants and codes for the ANSI-aware line truncator.
`timescale 1ns / 1ps
`default_nettype none

package alt_pkg;

   // Default sizes of the hold store and of one UTF-8 character.
   localparam int HoldDepthDefault    = 16;
   localparam int CharMaxBytesDefault = 4;

   // Register reset values and widths.
   localparam int BudgetWidth = 12;
   localparam int RoomWidth   = 16;
   localparam int CountWidth  = 16;
   localparam logic [BudgetWidth-1:0] BudgetReset = 12'd80;
   localparam logic [RoomWidth-1:0]   RoomReset   = 16'd1024;

   // Byte codes.
   localparam logic [7:0] EscByte     = 8'h1B;
   localparam logic [7:0] BracketByte = 8'h5B;
   localparam logic [7:0] ZeroByte    = 8'h30;
   localparam logic [7:0] SemiByte    = 8'h3B;
   localparam logic [7:0] MByte       = 8'h6D;
   localparam logic [7:0] ContMask    = 8'hC0;
   localparam logic [7:0] ContValue   = 8'h80;

   // Configuration register indexes.
   localparam logic CsrColumnBudget = 1'b0;
   localparam logic CsrByteRoom     = 1'b1;

   typedef enum logic [1:0] {
      PH_TEXT,
      PH_CHAR,
      PH_ESC,
      PH_CSI
   } phase_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FEED,
      S_REPLAY,
      S_REPLAY_LD,
      S_TEXT,
      S_START,
      S_EMITH_RD,
      S_EMITH_WR,
      S_EMIT_CUR,
      S_STOP,
      S_EOL_CHK,
      S_EOL_CLOSE,
      S_DONE
   } ctrl_state_type;

   // What the current unit of work returns to.
   typedef enum logic [1:0] {
      MODE_FEED_T,
      MODE_REPLAY_T,
      MODE_CSI_FINAL,
      MODE_EOL_CLOSE
   } mode_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_ESC_BRACKET,
      OP_DROP,
      OP_CSI_APPEND,
      OP_REPLAY_RD,
      OP_TB_FROM_MEM,
      OP_TB_FROM_CUR,
      OP_CHAR_APPEND,
      OP_CLOSE_BEGIN,
      OP_STOP,
      OP_EMIT_RD,
      OP_EMIT_MEM,
      OP_EMIT_CUR,
      OP_EMIT_RST,
      OP_COL_INC,
      OP_START,
      OP_EMIT_DONE
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      phase_type phase;
      logic      stopped;
      logic      painted;
      logic      has;
      logic      eol;
      logic      cur_bracket;
      logic      cur_param;
      logic      cur_final;
      logic      tb_cont;
      logic      char_room;
      logic      csi_room;
      logic      close_ovf;
      logic      csi_ovf;
      logic      budget_full;
      logic      replay_more;
      logic      emit_more;
      logic      rst_last;
      logic      slot_free;
   } status_type;

endpackage

`default_nettype wire

@@ hdl/ansi_aware_line_truncator.sv @@
// A transfer is accepted only while the sequencer is idle, so no byte is taken before
// the last is through. A plain byte passes the feed, text, start and line-end check
// states; a continuation byte skips start. A held unit is closed by emitting its bytes
// in turn, a line end adds the close and done states, replayed escape bytes are read
// back from the store, and output stalls extend all of these. Reset is synchronous,
// active high, restores register defaults, clears line control state, not the hold store.
`timescale 1ns / 1ps
`default_nettype none

module ansi_aware_line_truncator #(
   parameter int HOLD_DEPTH     = alt_pkg::HoldDepthDefault,
   parameter int CHAR_MAX_BYTES = alt_pkg::CharMaxBytesDefault
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // in_byte
   input  wire         req_tuser,   // has_byte
   input  wire         req_tlast,   // end_of_line
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [23:0] rsp_tdata,   // out_byte [7:0], bytes_out [23:8]
   output logic        rsp_tuser,   // byte_valid
   output logic        rsp_tlast,   // line_done
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire         csr_index,
   input  wire  [15:0] csr_data
);

   alt_pkg::cmd_type    cmd;
   alt_pkg::status_type st;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   alt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   alt_datapath #(
      .HOLD_DEPTH     (HOLD_DEPTH),
      .CHAR_MAX_BYTES (CHAR_MAX_BYTES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .st         (st)
   );

endmodule

`default_nettype wire

@@ hdl/alt_ctrl.sv @@
// Sequencer that steps the truncator datapath through each input byte.
`timescale 1ns / 1ps
`default_nettype none

module alt_ctrl (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_tvalid,
   output logic              req_tready,
   input  alt_pkg::status_type st,
   output alt_pkg::cmd_type  cmd
);

   alt_pkg::ctrl_state_type state_ff, state_in;
   alt_pkg::mode_type       mode_ff, mode_in;
   logic                    rcur_ff, rcur_in;
   alt_pkg::ctrl_state_type t_ret;

   // State, mode and replay flag registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= alt_pkg::S_IDLE;
         mode_ff  <= alt_pkg::MODE_FEED_T;
         rcur_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         rcur_ff  <= rcur_in;
      end
   end

   // Where a text-byte step returns to when it is finished.
   assign t_ret = (mode_ff == alt_pkg::MODE_REPLAY_T) ? alt_pkg::S_REPLAY : alt_pkg::S_EOL_CHK;

   // Next state and datapath command.
   always_comb begin
      state_in   = state_ff;
      mode_in    = mode_ff;
      rcur_in    = rcur_ff;
      cmd.op     = alt_pkg::OP_NONE;
      req_tready = 1'b0;
      case (state_ff)
         alt_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = alt_pkg::OP_LOAD;
               state_in = alt_pkg::S_FEED;
            end
         end
         alt_pkg::S_FEED: begin
            if (!st.has || st.stopped) begin
               state_in = alt_pkg::S_EOL_CHK;
            end else if (st.phase == alt_pkg::PH_ESC) begin
               if (st.cur_bracket) begin
                  cmd.op   = alt_pkg::OP_ESC_BRACKET;
                  state_in = alt_pkg::S_EOL_CHK;
               end else begin
                  cmd.op   = alt_pkg::OP_DROP;
                  rcur_in  = 1'b1;
                  state_in = alt_pkg::S_REPLAY;
               end
            end else if (st.phase == alt_pkg::PH_CSI) begin
               if (st.cur_param && st.csi_room) begin
                  cmd.op   = alt_pkg::OP_CSI_APPEND;
                  state_in = alt_pkg::S_EOL_CHK;
               end else if (st.cur_final) begin
                  mode_in = alt_pkg::MODE_CSI_FINAL;
                  if (st.csi_ovf) begin
                     cmd.op   = alt_pkg::OP_STOP;
                     state_in = alt_pkg::S_STOP;
                  end else begin
                     cmd.op   = alt_pkg::OP_CLOSE_BEGIN;
                     state_in = alt_pkg::S_EMITH_RD;
                  end
               end else begin
                  cmd.op   = alt_pkg::OP_DROP;
                  rcur_in  = 1'b1;
                  state_in = alt_pkg::S_REPLAY;
               end
            end else begin
               cmd.op   = alt_pkg::OP_TB_FROM_CUR;
               mode_in  = alt_pkg::MODE_FEED_T;
               state_in = alt_pkg::S_TEXT;
            end
         end
         alt_pkg::S_REPLAY: begin
            if (st.replay_more) begin
               cmd.op   = alt_pkg::OP_REPLAY_RD;
               state_in = alt_pkg::S_REPLAY_LD;
            end else if (rcur_ff) begin
               cmd.op   = alt_pkg::OP_TB_FROM_CUR;
               mode_in  = alt_pkg::MODE_FEED_T;
               state_in = alt_pkg::S_TEXT;
            end else begin
               state_in = alt_pkg::S_EOL_CLOSE;
            end
         end
         alt_pkg::S_REPLAY_LD: begin
            cmd.op   = alt_pkg::OP_TB_FROM_MEM;
            mode_in  = alt_pkg::MODE_REPLAY_T;
            state_in = alt_pkg::S_TEXT;
         end
         alt_pkg::S_TEXT: begin
            if (st.stopped) begin
               state_in = t_ret;
            end else if (st.phase == alt_pkg::PH_CHAR) begin
               if (st.tb_cont && st.char_room) begin
                  cmd.op   = alt_pkg::OP_CHAR_APPEND;
                  state_in = t_ret;
               end else if (st.close_ovf) begin
                  cmd.op   = alt_pkg::OP_STOP;
                  state_in = alt_pkg::S_STOP;
               end else begin
                  cmd.op   = alt_pkg::OP_CLOSE_BEGIN;
                  state_in = alt_pkg::S_EMITH_RD;
               end
            end else begin
               state_in = alt_pkg::S_START;
            end
         end
         alt_pkg::S_START: begin
            if (st.budget_full) begin
               cmd.op   = alt_pkg::OP_STOP;
               state_in = alt_pkg::S_STOP;
            end else begin
               cmd.op   = alt_pkg::OP_START;
               state_in = t_ret;
            end
         end
         alt_pkg::S_EMITH_RD: begin
            if (st.emit_more) begin
               cmd.op   = alt_pkg::OP_EMIT_RD;
               state_in = alt_pkg::S_EMITH_WR;
            end else if (mode_ff == alt_pkg::MODE_CSI_FINAL) begin
               state_in = alt_pkg::S_EMIT_CUR;
            end else if (mode_ff == alt_pkg::MODE_EOL_CLOSE) begin
               cmd.op   = alt_pkg::OP_COL_INC;
               state_in = alt_pkg::S_DONE;
            end else begin
               cmd.op   = alt_pkg::OP_COL_INC;
               state_in = alt_pkg::S_START;
            end
         end
         alt_pkg::S_EMITH_WR: begin
            if (st.slot_free) begin
               cmd.op   = alt_pkg::OP_EMIT_MEM;
               state_in = alt_pkg::S_EMITH_RD;
            end
         end
         alt_pkg::S_EMIT_CUR: begin
            if (st.slot_free) begin
               cmd.op   = alt_pkg::OP_EMIT_CUR;
               state_in = alt_pkg::S_EOL_CHK;
            end
         end
         alt_pkg::S_STOP: begin
            if (!st.painted || (st.slot_free && st.rst_last)) begin
               if (st.painted) begin
                  cmd.op = alt_pkg::OP_EMIT_RST;
               end
               if (mode_ff == alt_pkg::MODE_CSI_FINAL) begin
                  state_in = alt_pkg::S_EOL_CHK;
               end else if (mode_ff == alt_pkg::MODE_EOL_CLOSE) begin
                  state_in = alt_pkg::S_DONE;
               end else begin
                  state_in = t_ret;
               end
            end else if (st.slot_free) begin
               cmd.op = alt_pkg::OP_EMIT_RST;
            end
         end
         alt_pkg::S_EOL_CHK: begin
            if (!st.eol) begin
               state_in = alt_pkg::S_IDLE;
            end else if (!st.stopped &&
                         (st.phase == alt_pkg::PH_ESC || st.phase == alt_pkg::PH_CSI)) begin
               cmd.op   = alt_pkg::OP_DROP;
               rcur_in  = 1'b0;
               state_in = alt_pkg::S_REPLAY;
            end else begin
               state_in = alt_pkg::S_EOL_CLOSE;
            end
         end
         alt_pkg::S_EOL_CLOSE: begin
            mode_in = alt_pkg::MODE_EOL_CLOSE;
            if (!st.stopped && st.phase == alt_pkg::PH_CHAR) begin
               if (st.close_ovf) begin
                  cmd.op   = alt_pkg::OP_STOP;
                  state_in = alt_pkg::S_STOP;
               end else begin
                  cmd.op   = alt_pkg::OP_CLOSE_BEGIN;
                  state_in = alt_pkg::S_EMITH_RD;
               end
            end else begin
               state_in = alt_pkg::S_DONE;
            end
         end
         alt_pkg::S_DONE: begin
            if (st.slot_free) begin
               cmd.op   = alt_pkg::OP_EMIT_DONE;
               state_in = alt_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = alt_pkg::S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ hdl/alt_datapath.sv @@
// Hold store, line counters, configuration registers and output register.
`timescale 1ns / 1ps
`default_nettype none

module alt_datapath #(
   parameter int HOLD_DEPTH     = alt_pkg::HoldDepthDefault,
   parameter int CHAR_MAX_BYTES = alt_pkg::CharMaxBytesDefault
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire  [7:0]          req_tdata,
   input  wire                 req_tuser,
   input  wire                 req_tlast,
   input  wire                 csr_valid,
   input  wire                 csr_index,
   input  wire  [15:0]         csr_data,
   output logic                rsp_tvalid,
   input  wire                 rsp_tready,
   output logic [23:0]         rsp_tdata,
   output logic                rsp_tuser,
   output logic                rsp_tlast,
   input  alt_pkg::cmd_type    cmd,
   output alt_pkg::status_type st
);

   localparam int AW        = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
   localparam int CW        = $clog2(HOLD_DEPTH + 1);
   localparam int CharLimit = (CHAR_MAX_BYTES < HOLD_DEPTH) ? CHAR_MAX_BYTES : HOLD_DEPTH;

   // Hold store.
   logic [7:0]    mem [HOLD_DEPTH];
   logic [7:0]    rdata_ff;
   logic          we;
   logic [AW-1:0] waddr;
   logic [7:0]    wdata;
   logic          re;
   logic [AW-1:0] raddr;

   // Line state.
   logic [CW-1:0]                   hc_ff, ri_ff, rn_ff, ei_ff, en_ff;
   alt_pkg::phase_type              phase_ff;
   logic                            painted_ff, rc_ff, stopped_ff;
   logic [alt_pkg::CountWidth-1:0]  wc_ff;
   logic [alt_pkg::BudgetWidth-1:0] ct_ff;
   logic [7:0]                      cur_ff, tb_ff;
   logic                            has_ff, eol_ff;
   logic [1:0]                      si_ff;

   // Configuration registers.
   logic [alt_pkg::BudgetWidth-1:0] budget_ff;
   logic [alt_pkg::RoomWidth-1:0]   room_ff;

   // Output register.
   logic        ovalid_ff;
   logic [7:0]  obyte_ff;
   logic        obv_ff, odone_ff;
   logic [15:0] ototal_ff;

   logic        slot_free;
   logic [16:0] close_sum, csi_sum;
   logic [7:0]  rst_byte;
   logic [alt_pkg::CountWidth-1:0] wc_inc;

   assign slot_free = !ovalid_ff || rsp_tready;
   assign close_sum = {1'b0, wc_ff} + 17'(hc_ff);
   assign csi_sum   = close_sum + 17'd1;
   assign wc_inc    = (wc_ff != 16'hFFFF) ? wc_ff + 16'd1 : wc_ff;

   // Closing reset sequence byte.
   always_comb begin
      case (si_ff)
         2'd0:    rst_byte = alt_pkg::EscByte;
         2'd1:    rst_byte = alt_pkg::BracketByte;
         2'd2:    rst_byte = alt_pkg::ZeroByte;
         default: rst_byte = alt_pkg::MByte;
      endcase
   end

   // Store port selection.
   always_comb begin
      we    = 1'b0;
      waddr = hc_ff[AW-1:0];
      wdata = tb_ff;
      re    = 1'b0;
      raddr = ei_ff[AW-1:0];
      case (cmd.op)
         alt_pkg::OP_ESC_BRACKET: begin
            we    = 1'b1;
            waddr = AW'(1);
            wdata = alt_pkg::BracketByte;
         end
         alt_pkg::OP_CSI_APPEND: begin
            we    = 1'b1;
            wdata = cur_ff;
         end
         alt_pkg::OP_CHAR_APPEND: begin
            we = 1'b1;
         end
         alt_pkg::OP_START: begin
            we    = 1'b1;
            waddr = '0;
         end
         alt_pkg::OP_REPLAY_RD: begin
            re    = 1'b1;
            raddr = ri_ff[AW-1:0];
         end
         alt_pkg::OP_EMIT_RD: begin
            re = 1'b1;
         end
         default: begin
            we = 1'b0;
         end
      endcase
   end

   // Hold store write and registered read.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff <= alt_pkg::BudgetReset;
         room_ff   <= alt_pkg::RoomReset;
      end else if (csr_valid) begin
         if (csr_index == alt_pkg::CsrColumnBudget) begin
            budget_ff <= csr_data[alt_pkg::BudgetWidth-1:0];
         end else begin
            room_ff <= csr_data;
         end
      end
   end

   // Current byte payload and replay, emit and reset-sequence bookkeeping.
   always_ff @(posedge clock) begin
      case (cmd.op)
         alt_pkg::OP_LOAD: begin
            cur_ff <= req_tdata;
            has_ff <= req_tuser;
            eol_ff <= req_tlast;
         end
         alt_pkg::OP_DROP: begin
            rn_ff <= hc_ff;
            ri_ff <= CW'(1);
         end
         alt_pkg::OP_REPLAY_RD:   ri_ff <= ri_ff + CW'(1);
         alt_pkg::OP_TB_FROM_MEM: tb_ff <= rdata_ff;
         alt_pkg::OP_TB_FROM_CUR: tb_ff <= cur_ff;
         alt_pkg::OP_CLOSE_BEGIN: begin
            en_ff <= hc_ff;
            ei_ff <= '0;
         end
         alt_pkg::OP_EMIT_RD:     ei_ff <= ei_ff + CW'(1);
         alt_pkg::OP_STOP:        si_ff <= 2'd0;
         alt_pkg::OP_EMIT_RST:    si_ff <= si_ff + 2'd1;
         default: begin
            si_ff <= si_ff;
         end
      endcase
   end

   // Line control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         hc_ff      <= '0;
         phase_ff   <= alt_pkg::PH_TEXT;
         painted_ff <= 1'b0;
         rc_ff      <= 1'b1;
         wc_ff      <= '0;
         ct_ff      <= '0;
         stopped_ff <= 1'b0;
      end else begin
         case (cmd.op)
            alt_pkg::OP_ESC_BRACKET: begin
               hc_ff    <= CW'(2);
               phase_ff <= alt_pkg::PH_CSI;
               rc_ff    <= 1'b1;
            end
            alt_pkg::OP_DROP, alt_pkg::OP_CLOSE_BEGIN: begin
               hc_ff    <= '0;
               phase_ff <= alt_pkg::PH_TEXT;
            end
            alt_pkg::OP_CSI_APPEND: begin
               hc_ff <= hc_ff + CW'(1);
               if (cur_ff != alt_pkg::ZeroByte && cur_ff != alt_pkg::SemiByte) begin
                  rc_ff <= 1'b0;
               end
            end
            alt_pkg::OP_CHAR_APPEND: hc_ff <= hc_ff + CW'(1);
            alt_pkg::OP_STOP: begin
               stopped_ff <= 1'b1;
               hc_ff      <= '0;
               phase_ff   <= alt_pkg::PH_TEXT;
            end
            alt_pkg::OP_EMIT_MEM, alt_pkg::OP_EMIT_RST: wc_ff <= wc_inc;
            alt_pkg::OP_EMIT_CUR: begin
               wc_ff <= wc_inc;
               if (cur_ff == alt_pkg::MByte) begin
                  painted_ff <= !rc_ff;
               end
            end
            alt_pkg::OP_COL_INC: begin
               if (ct_ff != 12'hFFF) begin
                  ct_ff <= ct_ff + 12'd1;
               end
            end
            alt_pkg::OP_START: begin
               hc_ff    <= CW'(1);
               phase_ff <= (tb_ff == alt_pkg::EscByte) ? alt_pkg::PH_ESC : alt_pkg::PH_CHAR;
            end
            alt_pkg::OP_EMIT_DONE: begin
               hc_ff      <= '0;
               phase_ff   <= alt_pkg::PH_TEXT;
               painted_ff <= 1'b0;
               rc_ff      <= 1'b1;
               wc_ff      <= '0;
               ct_ff      <= '0;
               stopped_ff <= 1'b0;
            end
            default: begin
               hc_ff <= hc_ff;
            end
         endcase
      end
   end

   // Output register: a new transfer is loaded only when the slot is free.
   always_ff @(posedge clock) begin
      if (reset) begin
         ovalid_ff <= 1'b0;
      end else if (cmd.op == alt_pkg::OP_EMIT_MEM || cmd.op == alt_pkg::OP_EMIT_CUR ||
                   cmd.op == alt_pkg::OP_EMIT_RST || cmd.op == alt_pkg::OP_EMIT_DONE) begin
         ovalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         ovalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         alt_pkg::OP_EMIT_MEM: begin
            obyte_ff  <= rdata_ff;
            obv_ff    <= 1'b1;
            odone_ff  <= 1'b0;
            ototal_ff <= '0;
         end
         alt_pkg::OP_EMIT_CUR: begin
            obyte_ff  <= cur_ff;
            obv_ff    <= 1'b1;
            odone_ff  <= 1'b0;
            ototal_ff <= '0;
         end
         alt_pkg::OP_EMIT_RST: begin
            obyte_ff  <= rst_byte;
            obv_ff    <= 1'b1;
            odone_ff  <= 1'b0;
            ototal_ff <= '0;
         end
         alt_pkg::OP_EMIT_DONE: begin
            obyte_ff  <= '0;
            obv_ff    <= 1'b0;
            odone_ff  <= 1'b1;
            ototal_ff <= wc_ff;
         end
         default: begin
            obyte_ff <= obyte_ff;
         end
      endcase
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = {ototal_ff, obyte_ff};
   assign rsp_tuser  = obv_ff;
   assign rsp_tlast  = odone_ff;

   // Status toward the sequencer.
   always_comb begin
      st.phase       = phase_ff;
      st.stopped     = stopped_ff;
      st.painted     = painted_ff;
      st.has         = has_ff;
      st.eol         = eol_ff;
      st.cur_bracket = (cur_ff == alt_pkg::BracketByte);
      st.cur_param   = cur_ff inside {[8'h20:8'h3F]};
      st.cur_final   = cur_ff inside {[8'h40:8'h7E]};
      st.tb_cont     = ((tb_ff & alt_pkg::ContMask) == alt_pkg::ContValue);
      st.char_room   = (hc_ff < CW'(CharLimit));
      st.csi_room    = ((hc_ff + CW'(1)) < CW'(HOLD_DEPTH));
      st.close_ovf   = (close_sum > {1'b0, room_ff});
      st.csi_ovf     = (csi_sum > {1'b0, room_ff});
      st.budget_full = (ct_ff >= budget_ff);
      st.replay_more = (ri_ff < rn_ff);
      st.emit_more   = (ei_ff < en_ff);
      st.rst_last    = (si_ff == 2'd3);
      st.slot_free   = slot_free;
   end

endmodule

`default_nettype wire

@@ sim/ansi_aware_line_truncator_tb.sv @@
// Testbench for the ANSI-aware line truncator: directed lines, random lines, checked per byte.
`timescale 1ns / 1ps
`default_nettype none

module ansi_aware_line_truncator_tb;

   localparam int HoldDepth = 16;
   localparam int CharLimit = 4;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        byte_valid;
      logic        line_done;
      logic [15:0] bytes_out;
   } line_out_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [15:0] csr_data;

   // Predictor state and configuration.
   logic [11:0]        budget_m;
   logic [15:0]        room_m;
   logic [7:0]         held_m [HoldDepth];
   int                 held_n;
   alt_pkg::phase_type phase_m;
   bit                 painted_m;
   bit                 plain_reset_m;
   int                 written_m;
   int                 cols_m;
   bit                 stopped_m;

   line_out_type expected_q[$];
   int  error_count;
   int  rsp_count;
   int  sent_count;
   int  send_idle_pct;
   int  recv_idle_pct;
   int  hold_off_cycles;

   ansi_aware_line_truncator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------- Predictor ----------------

   function automatic void clear_line();
      held_n        = 0;
      phase_m       = alt_pkg::PH_TEXT;
      painted_m     = 1'b0;
      plain_reset_m = 1'b1;
      written_m     = 0;
      cols_m        = 0;
      stopped_m     = 1'b0;
   endfunction

   function automatic void push_out(logic [7:0] b);
      line_out_type r;
      r.out_byte   = b;
      r.byte_valid = 1'b1;
      r.line_done  = 1'b0;
      r.bytes_out  = '0;
      expected_q.push_back(r);
      if (written_m < 65535) written_m++;
   endfunction

   function automatic void halt_line();
      if (stopped_m) return;
      stopped_m = 1'b1;
      phase_m   = alt_pkg::PH_TEXT;
      held_n    = 0;
      if (painted_m) begin
         push_out(alt_pkg::EscByte);
         push_out(alt_pkg::BracketByte);
         push_out(alt_pkg::ZeroByte);
         push_out(alt_pkg::MByte);
      end
   endfunction

   function automatic void flush_char();
      int n;
      n       = held_n;
      phase_m = alt_pkg::PH_TEXT;
      held_n  = 0;
      if (n == 0) return;
      if (written_m + n > room_m) begin
         halt_line();
         return;
      end
      for (int i = 0; i < n; i++) push_out(held_m[i]);
      if (cols_m < 4095) cols_m++;
   endfunction

   function automatic void open_unit(logic [7:0] b);
      if (stopped_m) return;
      if (cols_m >= budget_m) begin
         halt_line();
         return;
      end
      held_m[0] = b;
      held_n    = 1;
      phase_m   = (b == alt_pkg::EscByte) ? alt_pkg::PH_ESC : alt_pkg::PH_CHAR;
   endfunction

   function automatic void plain_byte(logic [7:0] b);
      if (stopped_m) return;
      if (phase_m == alt_pkg::PH_CHAR) begin
         if ((b & alt_pkg::ContMask) == alt_pkg::ContValue && held_n < CharLimit) begin
            held_m[held_n] = b;
            held_n++;
            return;
         end
         flush_char();
      end
      open_unit(b);
   endfunction

   // A broken escape loses its ESC; the rest is replayed as text.
   function automatic void replay_escape();
      logic [7:0] copy [HoldDepth];
      int n;
      n = held_n;
      for (int i = 0; i < n; i++) copy[i] = held_m[i];
      held_n  = 0;
      phase_m = alt_pkg::PH_TEXT;
      for (int i = 1; i < n; i++) plain_byte(copy[i]);
   endfunction

   function automatic void take_byte(logic [7:0] b);
      if (stopped_m) return;
      if (phase_m == alt_pkg::PH_ESC) begin
         if (b == alt_pkg::BracketByte) begin
            held_m[1]     = b;
            held_n        = 2;
            phase_m       = alt_pkg::PH_CSI;
            plain_reset_m = 1'b1;
            return;
         end
         replay_escape();
         plain_byte(b);
         return;
      end
      if (phase_m == alt_pkg::PH_CSI) begin
         if (b >= 8'h20 && b < 8'h40) begin
            if (held_n + 1 < HoldDepth) begin
               held_m[held_n] = b;
               held_n++;
               if (b != alt_pkg::ZeroByte && b != alt_pkg::SemiByte) plain_reset_m = 1'b0;
               return;
            end
         end else if (b >= 8'h40 && b <= 8'h7E) begin
            if (written_m + held_n + 1 > room_m) begin
               halt_line();
               return;
            end
            for (int i = 0; i < held_n; i++) push_out(held_m[i]);
            push_out(b);
            if (b == alt_pkg::MByte) painted_m = !plain_reset_m;
            held_n  = 0;
            phase_m = alt_pkg::PH_TEXT;
            return;
         end
         replay_escape();
         plain_byte(b);
         return;
      end
      plain_byte(b);
   endfunction

   function automatic void predict_item(logic [7:0] b, logic has, logic eol);
      line_out_type r;
      if (has) take_byte(b);
      if (eol) begin
         if (!stopped_m && (phase_m == alt_pkg::PH_ESC || phase_m == alt_pkg::PH_CSI))
            replay_escape();
         if (!stopped_m && phase_m == alt_pkg::PH_CHAR) flush_char();
         r.out_byte   = '0;
         r.byte_valid = 1'b0;
         r.line_done  = 1'b1;
         r.bytes_out  = 16'(written_m);
         expected_q.push_back(r);
         clear_line();
      end
   endfunction

   // ---------------- Driving ----------------

   // The valid stays high after a transfer until the next item or an idle cycle replaces it.
   task automatic send_item(logic [7:0] b, logic has, logic eol);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= has;
      req_tlast  <= eol;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_item(b, has, eol);
      sent_count++;
   endtask

   task automatic send_line(logic [7:0] bytes[$]);
      foreach (bytes[i]) send_item(bytes[i], 1'b1, i == bytes.size() - 1);
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (60) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [15:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == alt_pkg::CsrColumnBudget) budget_m = value[11:0];
      else room_m = value;
   endtask

   // Receiver: random stalls plus an optional long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_tready      <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Compare each result transfer with the oldest expectation.
   always @(posedge clock) begin
      line_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_count <= rsp_count + 1;
         if (expected_q.size() == 0) begin
            $error("unexpected result: data %h user %b last %b", rsp_tdata, rsp_tuser,
                   rsp_tlast);
            error_count++;
         end else begin
            want = expected_q.pop_front();
            if (rsp_tdata[7:0] !== want.out_byte) begin
               $error("out_byte: expected %h, got %h", want.out_byte, rsp_tdata[7:0]);
               error_count++;
            end
            if (rsp_tuser !== want.byte_valid) begin
               $error("byte_valid: expected %b, got %b", want.byte_valid, rsp_tuser);
               error_count++;
            end
            if (rsp_tlast !== want.line_done) begin
               $error("line_done: expected %b, got %b", want.line_done, rsp_tlast);
               error_count++;
            end
            if (rsp_tdata[23:8] !== want.bytes_out) begin
               $error("bytes_out: expected %0d, got %0d", want.bytes_out, rsp_tdata[23:8]);
               error_count++;
            end
         end
      end
   end

   // ---------------- Tests ----------------

   function automatic logic [7:0] random_text_byte();
      case ($urandom_range(9))
         0, 1, 2: return 8'($urandom_range(8'h20, 8'h7E));
         3:       return 8'($urandom_range(8'hC0, 8'hF7));
         4, 5:    return 8'($urandom_range(8'h80, 8'hBF));
         6:       return alt_pkg::EscByte;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // Escape sequences, mostly well formed, with random parameters.
   task automatic add_escape(ref logic [7:0] line[$]);
      int n;
      line.push_back(alt_pkg::EscByte);
      if ($urandom_range(9) == 0) return;
      line.push_back(alt_pkg::BracketByte);
      n = ($urandom_range(7) == 0) ? $urandom_range(12, 16) : $urandom_range(3);
      for (int i = 0; i < n; i++)
         line.push_back($urandom_range(1) ?
                        (($urandom_range(1)) ? alt_pkg::ZeroByte : alt_pkg::SemiByte)
                        : 8'($urandom_range(8'h20, 8'h3F)));
      case ($urandom_range(5))
         0, 1, 2: line.push_back(alt_pkg::MByte);
         3:       line.push_back(8'($urandom_range(8'h40, 8'h7E)));
         4:       line.push_back(random_text_byte());
         default: ;
      endcase
   endtask

   task automatic test_directed();
      logic [7:0] line[$];
      line = '{8'h41, 8'h00, 8'hFF, 8'h7F};
      send_line(line);
      // Painted text then truncated by the column budget.
      line = '{alt_pkg::EscByte, alt_pkg::BracketByte, 8'h31, alt_pkg::MByte, 8'h61, 8'h62,
               8'h63, 8'h64, 8'h65};
      write_reg(alt_pkg::CsrColumnBudget, 16'd2);
      send_line(line);
      // Reset escape, UTF-8 character and an overlong character.
      line = '{alt_pkg::EscByte, alt_pkg::BracketByte, alt_pkg::ZeroByte, alt_pkg::SemiByte,
               alt_pkg::MByte, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h80, 8'h80, 8'h80, 8'h80};
      write_reg(alt_pkg::CsrColumnBudget, 16'd4095);
      send_line(line);
      // Broken escape, then an escape left open at the line end.
      line = '{alt_pkg::EscByte, 8'h41, alt_pkg::EscByte, alt_pkg::BracketByte, 8'h32};
      send_line(line);
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'h5A, 1'b0, 1'b0);
      send_item(8'h42, 1'b1, 1'b1);
   endtask

   task automatic test_limits();
      logic [7:0] line[$];
      line = '{alt_pkg::EscByte, alt_pkg::BracketByte, 8'h34, alt_pkg::MByte, 8'h41, 8'h42};
      write_reg(alt_pkg::CsrByteRoom, 16'd0);
      send_line(line);
      write_reg(alt_pkg::CsrByteRoom, 16'd5);
      send_line(line);
      write_reg(alt_pkg::CsrColumnBudget, 16'd1);
      write_reg(alt_pkg::CsrByteRoom, 16'd65535);
      send_line(line);
   endtask

   task automatic random_lines(int count);
      logic [7:0] line[$];
      int target;
      target = sent_count + count;
      while (sent_count < target) begin
         line.delete();
         for (int k = $urandom_range(1, 8); k > 0; k--) begin
            if ($urandom_range(3) == 0) add_escape(line);
            else line.push_back(random_text_byte());
         end
         if ($urandom_range(15) == 0) send_item(8'($urandom), 1'b0, 1'b0);
         send_line(line);
      end
   endtask

   task automatic test_random();
      send_idle_pct = 31; recv_idle_pct = 52;
      write_reg(alt_pkg::CsrColumnBudget, 16'($urandom_range(1, 6)));
      write_reg(alt_pkg::CsrByteRoom, 16'($urandom_range(4, 30)));
      random_lines(90);
      send_idle_pct = 52; recv_idle_pct = 31;
      write_reg(alt_pkg::CsrColumnBudget, 16'd3);
      write_reg(alt_pkg::CsrByteRoom, 16'd1024);
      random_lines(80);
      send_idle_pct = 0; recv_idle_pct = 0;
      write_reg(alt_pkg::CsrColumnBudget, 16'd80);
      random_lines(70);
   endtask

   task automatic test_backpressure();
      drain();
      hold_off_cycles = 400;
      random_lines(20);
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0; req_tdata = '0; req_tuser = 1'b0; req_tlast = 1'b0;
      csr_valid = 1'b0; csr_index = alt_pkg::CsrColumnBudget; csr_data = '0;
      error_count = 0; rsp_count = 0; sent_count = 0;
      send_idle_pct = 0; recv_idle_pct = 0; hold_off_cycles = 0;
      budget_m = alt_pkg::BudgetReset; room_m = alt_pkg::RoomReset;
      clear_line();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_limits();
      test_random();
      test_backpressure();
      drain();
      $display("Sent %0d input items and checked %0d result transfers,", sent_count,
               rsp_count);
      $display("across budgets, byte room limits, escapes and UTF-8 characters.");
      if (error_count == 0 && expected_q.size() == 0) begin
         $display("== PASS ==");
      end else begin
         if (expected_q.size() != 0) $error("%0d results never arrived", expected_q.size());
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("== FAIL ==");
      $finish;
   end

endmodule

`default_nettype wire
